// File: hw/rtl/smrle_pkg.sv
// ----------------------------------------------------------------------------
// smrle_pkg
// Shared types and constants of the sprite mask run-length encoder.
// ----------------------------------------------------------------------------
package smrle_pkg;

	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int COLOR_W     = 8;
	localparam int RUN_W       = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [RUN_W-1:0] RUN_CAP = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRANSPARENT = 2'd0,
		REG_ROW_WIDTH   = 2'd1,
		REG_ROW_COUNT   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RES_SPLIT = 2'd0,
		RES_PEND  = 2'd1,
		RES_EOL   = 2'd2
	} res_kind_t;

	// Results caused by one pixel: an optional split pair, then at row end
	// the pending pair and the end-of-line marker.
	typedef struct packed {
		logic             split_valid;
		logic [RUN_W-1:0] split_skip;
		logic [RUN_W-1:0] split_draw;
		logic             eol_valid;
		logic [RUN_W-1:0] pend_skip;
		logic [RUN_W-1:0] pend_draw;
		logic             last_row;
	} smrle_group_t;

endpackage

// File: hw/rtl/smrle_front.sv
// ----------------------------------------------------------------------------
// smrle_front
// Configuration registers, pixel classification and run tracking. Builds one
// result group per pixel that causes any result.
// ----------------------------------------------------------------------------
module smrle_front
	import smrle_pkg::*;
#(
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_ROWS      = 1024,
	parameter int PIXEL_BITS    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic                  q_full,
	output logic                  push,
	output smrle_group_t          push_group
);

	localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [COLOR_W-1:0] color_q;
	logic [CFG_W-1:0]   row_width_q;
	logic [CFG_W-1:0]   row_count_q;

	logic               opaque_q;
	logic [RUN_W-1:0]   skip_q;
	logic [RUN_W-1:0]   draw_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;

	logic [15:0]        color_ext;
	logic               transp;
	logic [CFG_W-1:0]   w_eff;
	logic [CFG_W-1:0]   h_eff;
	logic               row_end;
	logic               last_row;
	logic               accept;

	logic               opaque_d;
	logic [RUN_W-1:0]   skip_d;
	logic [RUN_W-1:0]   draw_d;
	smrle_group_t       grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q     <= '0;
			row_width_q <= CFG_W'(16);
			row_count_q <= CFG_W'(16);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_TRANSPARENT: color_q     <= cfg_data[COLOR_W-1:0];
				REG_ROW_WIDTH:   row_width_q <= cfg_data;
				REG_ROW_COUNT:   row_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign color_ext = 16'(color_q);
	assign transp    = (pixel == color_ext[PIXEL_BITS-1:0]);

	always_comb begin
		if (row_width_q == '0)
			w_eff = CFG_W'(1);
		else if (32'(row_width_q) > MAX_ROW_WIDTH)
			w_eff = CFG_W'(MAX_ROW_WIDTH);
		else
			w_eff = row_width_q;
		if (row_count_q == '0)
			h_eff = CFG_W'(1);
		else if (32'(row_count_q) > MAX_ROWS)
			h_eff = CFG_W'(MAX_ROWS);
		else
			h_eff = row_count_q;
	end

	assign row_end  = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign last_row = (32'(row_q) + 32'd1) >= 32'(h_eff);
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		opaque_d        = opaque_q;
		skip_d          = skip_q;
		draw_d          = draw_q;
		grp             = '0;
		if (!opaque_q) begin
			if (transp) begin
				if (skip_q >= RUN_CAP) begin
					grp.split_valid = 1'b1;
					grp.split_skip  = RUN_CAP;
					grp.split_draw  = '0;
					skip_d          = RUN_W'(1);
				end else begin
					skip_d = skip_q + RUN_W'(1);
				end
			end else begin
				opaque_d = 1'b1;
				draw_d   = RUN_W'(1);
			end
		end else begin
			if (transp) begin
				grp.split_valid = 1'b1;
				grp.split_skip  = skip_q;
				grp.split_draw  = draw_q;
				skip_d          = RUN_W'(1);
				draw_d          = '0;
				opaque_d        = 1'b0;
			end else if (draw_q >= RUN_CAP) begin
				grp.split_valid = 1'b1;
				grp.split_skip  = skip_q;
				grp.split_draw  = RUN_CAP;
				skip_d          = '0;
				draw_d          = RUN_W'(1);
			end else begin
				draw_d = draw_q + RUN_W'(1);
			end
		end
		grp.eol_valid = row_end;
		grp.pend_skip = skip_d;
		grp.pend_draw = draw_d;
		grp.last_row  = last_row;
	end

	assign push       = accept && (grp.split_valid || grp.eol_valid);
	assign push_group = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opaque_q <= 1'b0;
			skip_q   <= '0;
			draw_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (row_end) begin
				opaque_q <= 1'b0;
				skip_q   <= '0;
				draw_q   <= '0;
				col_q    <= '0;
				row_q    <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				opaque_q <= opaque_d;
				skip_q   <= skip_d;
				draw_q   <= draw_d;
				col_q    <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// File: hw/rtl/smrle_queue.sv
// ----------------------------------------------------------------------------
// smrle_queue
// Short queue of result groups between the run tracker and the emitter.
// ----------------------------------------------------------------------------
module smrle_queue
	import smrle_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  smrle_group_t wr_group,
	input  logic         pop,
	output smrle_group_t rd_group,
	output logic         empty,
	output logic         full
);

	smrle_group_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_group = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_group;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

// File: hw/rtl/smrle_back.sv
// ----------------------------------------------------------------------------
// smrle_back
// Result emitter: walks each queued group one result per transfer and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module smrle_back
	import smrle_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  smrle_group_t     head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RUN_W-1:0] skip_count,
	output logic [RUN_W-1:0] draw_count,
	output logic             end_of_line,
	output logic             end_of_block,
	output logic             last_of_run
);

	logic [1:0]       step_q;
	logic             out_valid_q;
	logic [RUN_W-1:0] skip_q;
	logic [RUN_W-1:0] draw_q;
	logic             eol_q;
	logic             eob_q;
	logic             last_q;

	logic             load;
	res_kind_t        kind;
	res_kind_t        final_kind;
	logic             is_last;
	logic [RUN_W-1:0] res_skip;
	logic [RUN_W-1:0] res_draw;
	logic             res_eol;
	logic             res_eob;

	assign load       = !out_valid_q || out_ready;
	assign kind       = res_kind_t'(2'(step_q + {1'b0, !head.split_valid}));
	assign final_kind = head.eol_valid ? RES_EOL : RES_SPLIT;
	assign is_last    = (kind == final_kind);
	assign pop        = load && !empty && is_last;

	always_comb begin
		res_skip = '0;
		res_draw = '0;
		res_eol  = 1'b0;
		res_eob  = 1'b0;
		case (kind)
			RES_SPLIT: begin
				res_skip = head.split_skip;
				res_draw = head.split_draw;
			end
			RES_PEND: begin
				res_skip = head.pend_skip;
				res_draw = head.pend_draw;
			end
			RES_EOL: begin
				res_eol = 1'b1;
				res_eob = head.last_row;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty)
				step_q <= is_last ? 2'd0 : step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			skip_q <= res_skip;
			draw_q <= res_draw;
			eol_q  <= res_eol;
			eob_q  <= res_eob;
			last_q <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign skip_count   = skip_q;
	assign draw_count   = draw_q;
	assign end_of_line  = eol_q;
	assign end_of_block = eob_q;
	assign last_of_run  = last_q;

endmodule

// File: hw/rtl/sprite_mask_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// sprite_mask_run_length_encoder_top
// Transparent-pixel run-length encoder for sprite blocks.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle, as long as the four-entry
// result-group queue has room. The run tracker classifies a pixel in the cycle
// it is accepted, and each pixel that causes results (a split pair, or at row
// end the pending pair plus the end-of-line marker) places one group in the
// queue at that edge. The emitter sends one result per cycle from its output
// register while out_ready is high, so a row end costs up to three results and
// the queue depth sets how many row ends can be absorbed while the output side
// stalls. A pixel's first result passes through its queue entry and then the
// output register. Configuration writes take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module sprite_mask_run_length_encoder_top
	import smrle_pkg::*;
#(
	parameter int MAX_ROW_WIDTH = 1024,
	parameter int MAX_ROWS      = 1024,
	parameter int PIXEL_BITS    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RUN_W-1:0]      skip_count,
	output logic [RUN_W-1:0]      draw_count,
	output logic                  end_of_line,
	output logic                  end_of_block,
	output logic                  last_of_run
);

	logic         q_full;
	logic         q_empty;
	logic         push;
	logic         pop;
	smrle_group_t push_group;
	smrle_group_t head;

	smrle_front #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH),
		.MAX_ROWS      (MAX_ROWS),
		.PIXEL_BITS    (PIXEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.q_full     (q_full),
		.push       (push),
		.push_group (push_group)
	);

	smrle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_group (push_group),
		.pop      (pop),
		.rd_group (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	smrle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.skip_count   (skip_count),
		.draw_count   (draw_count),
		.end_of_line  (end_of_line),
		.end_of_block (end_of_block),
		.last_of_run  (last_of_run)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("group pushed into full queue");

	a_eob_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_block) |-> end_of_line)
		else $error("end of block outside end-of-line marker");

	a_eol_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_line) |->
			(skip_count == '0 && draw_count == '0 && last_of_run))
		else $error("malformed end-of-line marker");

	a_pop_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("group retired without a result");

endmodule
